// ===== hdl/vlt_pkg.sv =====
// Shared types and constants for the variable lock table.
package vlt_pkg;

	// Default sizing of the table
	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned KEY_BITS_DEF    = 64;
	localparam int unsigned OWNER_BITS_DEF  = 16;

	// Field widths on the stream ports
	localparam int unsigned CMD_W        = 2;
	localparam int unsigned KEY_FIELD_W  = 64;
	localparam int unsigned OWN_FIELD_W  = 16;
	localparam int unsigned KEY_LSB      = CMD_W;
	localparam int unsigned OWN_LSB      = CMD_W + KEY_FIELD_W;
	localparam int unsigned S_FIELDS_W   = CMD_W + KEY_FIELD_W + OWN_FIELD_W;
	localparam int unsigned S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W    = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CHECK      = 2'd0,
		CMD_PLACE      = 2'd1,
		CMD_REMOVE     = 2'd2,
		CMD_REMOVE_ALL = 2'd3
	} cmd_t;

endpackage

// ===== hdl/vlt_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
module vlt_ram #(
	parameter int unsigned WIDTH  = 81,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/variable_lock_table_core.sv =====
// Top level of the variable lock table: command sequencer around the entry memory.
//
//  channel   dir  tdata fields (lsb first)                         tuser/tlast
//  s_axis    in   cmd[1:0], var_key[65:2], owner_id[81:66], pad    none
//  m_axis    out  success[0], table_full[1], pad                   none
//
// Each command scans every entry once through the memory read port before the
// result is loaded into the output register.
// The single memory read port, one entry a cycle, sets the length of a scan.
// After reset a clearing pass writes every entry to zero before s_tready rises.
// A new command is taken while the previous result waits on m_tready; a
// finished scan holds in its last state until the output register is free.
module variable_lock_table_core #(
	parameter int unsigned TABLE_DEPTH = vlt_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned KEY_BITS    = vlt_pkg::KEY_BITS_DEF,
	parameter int unsigned OWNER_BITS  = vlt_pkg::OWNER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vlt_pkg::S_TDATA_W-1:0] s_tdata,  // cmd, var_key, owner_id, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vlt_pkg::M_TDATA_W-1:0] m_tdata   // success, table_full, zero pad
);

	localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned OWN_W  = (OWNER_BITS < vlt_pkg::OWN_FIELD_W) ?
		OWNER_BITS : vlt_pkg::OWN_FIELD_W;
	localparam int unsigned ENT_W  = 1 + KEY_BITS + OWN_W;
	localparam int unsigned KEY_LO = 1;
	localparam int unsigned OWN_LO = 1 + KEY_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	vlt_pkg::cmd_t        cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [OWN_W-1:0]     own_q;
	logic                 found_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 m_tvalid_q;
	logic [vlt_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENT_W-1:0]     wr_data;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [ENT_W-1:0]     rd_data;

	logic                 ent_valid;
	logic [KEY_BITS-1:0]  ent_key;
	logic [OWN_W-1:0]     ent_own;
	logic                 key_hit;
	logic                 own_hit;
	logic                 kill_s1;
	logic                 last_s1;
	logic                 out_free;
	logic                 place_ok;
	logic                 place_full;
	logic                 res_ok;
	logic                 res_full;
	logic                 s_xfer;

	vlt_ram #(
		.WIDTH  (ENT_W),
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign ent_valid = rd_data[0];
	assign ent_key   = rd_data[KEY_LO +: KEY_BITS];
	assign ent_own   = rd_data[OWN_LO +: OWN_W];
	assign key_hit   = ent_valid && (ent_key == key_q);
	assign own_hit   = ent_valid && (ent_own == own_q);
	assign last_s1   = valid_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));

	// Remove frees only the first key match; remove-all frees every owner match
	always_comb begin
		unique case (cmd_q)
			vlt_pkg::CMD_CHECK:      kill_s1 = 1'b0;
			vlt_pkg::CMD_PLACE:      kill_s1 = 1'b0;
			vlt_pkg::CMD_REMOVE:     kill_s1 = key_hit && !found_q;
			vlt_pkg::CMD_REMOVE_ALL: kill_s1 = own_hit;
			default:                 kill_s1 = 1'b0;
		endcase
	end

	assign place_ok   = (cmd_q == vlt_pkg::CMD_PLACE) && !found_q && free_found_q;
	assign place_full = (cmd_q == vlt_pkg::CMD_PLACE) && !found_q && !free_found_q;
	assign res_ok     = (cmd_q == vlt_pkg::CMD_PLACE) ? place_ok : found_q;
	assign res_full   = place_full;

	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(TABLE_DEPTH));
	assign rd_addr = cnt_q[IDX_W-1:0];

	// One write port: clearing pass, invalidate during scan, or lock placement
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = {rd_data[ENT_W-1:1], 1'b0};
		priority if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[IDX_W-1:0];
			wr_data = '0;
		end else if (state_q == ST_SCAN) begin
			wr_en = valid_s1 && kill_s1;
		end else if (state_q == ST_DONE) begin
			wr_en   = out_free && place_ok;
			wr_addr = free_idx_q;
			wr_data = {own_q, key_q, 1'b1};
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			cmd_q        <= vlt_pkg::CMD_CHECK;
			key_q        <= '0;
			own_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// the finish state reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			valid_s1 <= rd_en;
			if (rd_en) begin
				idx_s1 <= cnt_q[IDX_W-1:0];
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_xfer) begin
						cmd_q        <= vlt_pkg::cmd_t'(s_tdata[vlt_pkg::CMD_W-1:0]);
						key_q        <= s_tdata[vlt_pkg::KEY_LSB +: KEY_BITS];
						own_q        <= s_tdata[vlt_pkg::OWN_LSB +: OWN_W];
						cnt_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (valid_s1) begin
						if ((cmd_q == vlt_pkg::CMD_REMOVE_ALL) ? own_hit : key_hit) begin
							found_q <= 1'b1;
						end
						if (!ent_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
					end
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= vlt_pkg::M_TDATA_W'({res_full, res_ok});
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A scan never writes back the entry it is reading in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("scan writes the entry being read");

	// Results only come out of the final scan state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside of the finish state");

	// Place failure and success are exclusive
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("success and table_full both set");

	// An accepted command starts its scan at entry zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> (state_q == ST_SCAN && cnt_q == '0 && !found_q))
		else $error("scan did not start cleanly");

endmodule
